FILE: design/length_prefixed_frame_deframer_assert.svh
// Assertion macros shared by the deframer checker.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define LPFD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define LPFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/lpfd_pkg.sv
// Types and constants of the length-prefixed frame deframer.
`timescale 1ns / 1ps
package lpfd_pkg;

  localparam logic       OP_BYTE         = 1'b0;
  localparam logic       OP_RESYNC       = 1'b1;

  localparam logic [1:0] KIND_GOOD       = 2'd0;
  localparam logic [1:0] KIND_BAD_LEN    = 2'd1;
  localparam logic [1:0] KIND_BAD_SUM    = 2'd2;

  localparam logic       REG_TYPE_LOW    = 1'b0;
  localparam logic       REG_TYPE_HIGH   = 1'b1;

  localparam logic [7:0] TYPE_LOW_RESET  = 8'd1;
  localparam logic [7:0] TYPE_HIGH_RESET = 8'd4;

  localparam logic [7:0] HDR_FIXED       = 8'd6;
  localparam logic [7:0] POS_COMMAND     = 8'd2;
  localparam logic [7:0] POS_ADDRESS     = 8'd3;
  localparam logic [7:0] POS_STATUS      = 8'd4;
  localparam logic [7:0] POS_PAYLOAD     = 8'd5;
  localparam logic [7:0] RUN_LIMIT       = 8'd26;

  localparam int IDX_W  = 5;
  localparam int ADDR_W = IDX_W + 1;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frame_type;
    logic [7:0]  command;
    logic [7:0]  address;
    logic [7:0]  dev_status;
    logic [4:0]  body_len;
    logic [4:0]  payload_index;
    logic [7:0]  payload_byte;
    logic [31:0] frame_seq;
    logic [31:0] invalid_total;
    logic        last;
  } out_t;

  // One finished frame or error, handed from parser to emitter.
  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       frame_type;
    logic [7:0]       command;
    logic [7:0]       address;
    logic [7:0]       dev_status;
    logic [4:0]       body_len;
    logic [IDX_W-1:0] run_len;
    logic             bank;
    logic [31:0]      frame_seq;
    logic [31:0]      invalid_total;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } bank_free_t;

  typedef struct packed {
    logic       en;
    logic       index;
    logic [7:0] data;
  } cfg_wr_t;

endpackage

FILE: design/lpfd_front.sv
// Byte parser: frame hunt, length check, checksum, counters and payload writes.
`timescale 1ns / 1ps
module lpfd_front #(
  parameter int FRAME_MAX = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lpfd_pkg::in_t       in_item,
  output logic                full,
  input  lpfd_pkg::cfg_wr_t   cfg,
  output logic                q_push,
  output lpfd_pkg::job_t      q_job,
  input  logic                q_full,
  output lpfd_pkg::mem_wr_t   mem_wr,
  input  lpfd_pkg::bank_free_t bank_free
);

  localparam int CW = $clog2(FRAME_MAX + 1);
  localparam logic [7:0] LEN_MAX = 8'(FRAME_MAX);
  localparam int IDX_W_L = lpfd_pkg::IDX_W;

  logic [7:0]    type_low;
  logic [7:0]    type_high;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] exp_len, exp_len_next;
  logic [7:0]    run_xor, run_xor_next;
  logic [7:0]    ptype, ptype_next;
  logic [7:0]    cmd, cmd_next;
  logic [7:0]    addr, addr_next;
  logic [7:0]    stat, stat_next;
  logic [31:0]   seq, seq_next;
  logic [31:0]   bad, bad_next;
  logic [1:0]    busy, busy_next;
  logic          wbank, wbank_next;

  logic          accept;
  logic [7:0]    b;
  logic          type_ok;
  logic          len_bad;
  logic [7:0]    count8;
  logic [CW-1:0] exp_eff;
  logic [CW-1:0] count_inc;
  logic [7:0]    xor_new;
  logic [7:0]    plen8;
  logic [7:0]    pay_off;
  logic [31:0]   seq_inc;
  logic [IDX_W_L-1:0] run_len;

  assign full    = q_full || busy[wbank];
  assign accept  = push && !full;
  assign b       = in_item.rx_byte;
  assign type_ok = (b >= type_low) && (b <= type_high);
  assign len_bad = (b < lpfd_pkg::HDR_FIXED) || (b > LEN_MAX);
  assign count8  = 8'(count);
  assign count_inc = count + CW'(1);
  assign exp_eff = (count == CW'(1)) ? CW'(b) : exp_len;
  assign xor_new = run_xor ^ b;
  assign plen8   = 8'(exp_eff) - lpfd_pkg::HDR_FIXED;
  assign pay_off = count8 - lpfd_pkg::POS_PAYLOAD;
  assign seq_inc = seq + 32'd1;
  assign run_len = (plen8 > lpfd_pkg::RUN_LIMIT) ? IDX_W_L'(lpfd_pkg::RUN_LIMIT)
                                                 : plen8[IDX_W_L-1:0];

  always_comb begin
    count_next   = count;
    exp_len_next = exp_len;
    run_xor_next = run_xor;
    ptype_next   = ptype;
    cmd_next     = cmd;
    addr_next    = addr;
    stat_next    = stat;
    seq_next     = seq;
    bad_next     = bad;
    busy_next    = busy;
    wbank_next   = wbank;
    q_push       = 1'b0;
    q_job        = '0;
    mem_wr       = '0;

    if (bank_free.en) begin
      busy_next[bank_free.bank] = 1'b0;
    end

    if (accept) begin
      if (in_item.op == lpfd_pkg::OP_RESYNC) begin
        count_next   = '0;
        exp_len_next = '0;
      end else if (count == '0) begin
        if (type_ok) begin
          ptype_next   = b;
          run_xor_next = b;
          count_next   = CW'(1);
          exp_len_next = '0;
        end
      end else if (count == CW'(1) && len_bad) begin
        // Report the abandoned frame, then retry the byte as a type byte.
        bad_next            = bad + 32'd1;
        q_push              = 1'b1;
        q_job.kind          = lpfd_pkg::KIND_BAD_LEN;
        q_job.frame_type    = ptype;
        q_job.frame_seq     = seq;
        q_job.invalid_total = bad + 32'd1;
        count_next          = '0;
        exp_len_next        = '0;
        if (type_ok) begin
          ptype_next   = b;
          run_xor_next = b;
          count_next   = CW'(1);
        end
      end else begin
        exp_len_next = exp_eff;
        case (count8)
          lpfd_pkg::POS_COMMAND: begin
            cmd_next = b;
          end
          lpfd_pkg::POS_ADDRESS: begin
            addr_next = b;
          end
          lpfd_pkg::POS_STATUS: begin
            stat_next = b;
          end
          default: begin
          end
        endcase
        if (count8 >= lpfd_pkg::POS_PAYLOAD && pay_off < lpfd_pkg::RUN_LIMIT) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = {wbank, pay_off[IDX_W_L-1:0]};
          mem_wr.data = b;
        end
        run_xor_next = xor_new;
        count_next   = count_inc;
        if (!(count_inc < exp_eff)) begin
          count_next          = '0;
          exp_len_next        = '0;
          q_push              = 1'b1;
          q_job.frame_type    = ptype;
          q_job.command       = cmd;
          q_job.address       = addr;
          q_job.dev_status    = stat;
          q_job.body_len      = plen8[4:0];
          q_job.bank          = wbank;
          if (xor_new != 8'hFF) begin
            bad_next            = bad + 32'd1;
            q_job.kind          = lpfd_pkg::KIND_BAD_SUM;
            q_job.frame_seq     = seq;
            q_job.invalid_total = bad + 32'd1;
          end else begin
            // Sequence skips zero on wrap.
            seq_next            = (seq_inc == 32'd0) ? 32'd1 : seq_inc;
            q_job.kind          = lpfd_pkg::KIND_GOOD;
            q_job.frame_seq     = (seq_inc == 32'd0) ? 32'd1 : seq_inc;
            q_job.invalid_total = bad;
            q_job.run_len       = run_len;
            if (run_len != '0) begin
              busy_next[wbank] = 1'b1;
              wbank_next       = !wbank;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      type_low  <= lpfd_pkg::TYPE_LOW_RESET;
      type_high <= lpfd_pkg::TYPE_HIGH_RESET;
      count     <= '0;
      exp_len   <= '0;
      run_xor   <= '0;
      seq       <= '0;
      bad       <= '0;
      busy      <= '0;
      wbank     <= 1'b0;
    end else begin
      count   <= count_next;
      exp_len <= exp_len_next;
      run_xor <= run_xor_next;
      seq     <= seq_next;
      bad     <= bad_next;
      busy    <= busy_next;
      wbank   <= wbank_next;
      if (cfg.en) begin
        case (cfg.index)
          lpfd_pkg::REG_TYPE_LOW: begin
            type_low <= cfg.data;
          end
          lpfd_pkg::REG_TYPE_HIGH: begin
            type_high <= cfg.data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ptype <= ptype_next;
    cmd   <= cmd_next;
    addr  <= addr_next;
    stat  <= stat_next;
  end

endmodule

FILE: design/lpfd_queue.sv
// Two-entry descriptor queue between the parser and the emitter.
`timescale 1ns / 1ps
module lpfd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lpfd_pkg::job_t job_in,
  output logic           full,
  input  logic           pop,
  output lpfd_pkg::job_t job_out,
  output logic           not_empty
);

  lpfd_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign job_out   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= job_in;
    end
  end

endmodule

FILE: design/lpfd_back.sv
// Emitter: payload store, run sequencing and the result register.
`timescale 1ns / 1ps
module lpfd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  lpfd_pkg::mem_wr_t    mem_wr,
  input  lpfd_pkg::job_t       q_job,
  input  logic                 q_not_empty,
  output logic                 q_pop,
  output lpfd_pkg::bank_free_t bank_free,
  output logic                 empty,
  input  logic                 pop,
  output lpfd_pkg::out_t       result
);

  localparam int IW = lpfd_pkg::IDX_W;
  localparam int AW = lpfd_pkg::ADDR_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SINGLE = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;

  logic [7:0]     mem [2**AW];
  logic [7:0]     rdata;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;

  logic [1:0]     state;
  lpfd_pkg::job_t job;
  logic [IW-1:0]  idx;
  logic           out_valid;
  logic           slot_free;
  logic           run_last;
  logic           load;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign run_last  = (idx == job.run_len - IW'(1));
  assign q_pop     = (state == ST_IDLE) && q_not_empty;
  assign load      = slot_free && (state == ST_SINGLE || state == ST_RUN);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state == ST_IDLE && q_not_empty) begin
      rd_en   = 1'b1;
      rd_addr = {q_job.bank, IW'(0)};
    end else if (state == ST_RUN && slot_free && !run_last) begin
      // Fetch the next byte while the current one loads into the result.
      rd_en   = 1'b1;
      rd_addr = {job.bank, idx + IW'(1)};
    end
  end

  assign bank_free.en   = (state == ST_RUN) && slot_free && run_last;
  assign bank_free.bank = job.bank;

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr] <= mem_wr.data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_not_empty) begin
            state <= (q_job.run_len == '0) ? ST_SINGLE : ST_RUN;
          end
        end
        ST_SINGLE: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        ST_RUN: begin
          if (slot_free && run_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_not_empty) begin
      job <= q_job;
      idx <= '0;
    end else if (state == ST_RUN && slot_free && !run_last) begin
      idx <= idx + IW'(1);
    end
    if (load) begin
      result.kind          <= job.kind;
      result.frame_type    <= job.frame_type;
      result.command       <= job.command;
      result.address       <= job.address;
      result.dev_status    <= job.dev_status;
      result.body_len      <= job.body_len;
      result.frame_seq     <= job.frame_seq;
      result.invalid_total <= job.invalid_total;
      if (state == ST_RUN) begin
        result.payload_index <= idx;
        result.payload_byte  <= rdata;
        result.last          <= run_last;
      end else begin
        result.payload_index <= '0;
        result.payload_byte  <= '0;
        result.last          <= 1'b1;
      end
    end
  end

endmodule

FILE: design/length_prefixed_frame_deframer.sv
// Top level of the length-prefixed frame deframer.
// The parser takes one received byte (or a resync) per cycle whenever full is low;
// it finds a frame by a type byte in type_low..type_high and a length byte of
// 6..FRAME_MAX, checks the inverted-XOR checksum and hands each finished frame or
// error to a two-entry descriptor queue. Payload bytes go into one of two banks of
// a 64-byte store, so the next frame can be parsed while the previous payload is
// emitted. The emitter takes a descriptor in its idle state and then shows one
// result per cycle: a good frame with payload gives min(length - 6, 26) results,
// every other event one. full rises while the queue holds two descriptors or while
// the bank that the parser writes next is still being emitted. Results wait in an
// output register; a stalled pop holds the emitter, not the parser.
`timescale 1ns / 1ps
module length_prefixed_frame_deframer #(
  parameter int FRAME_MAX = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lpfd_pkg::in_t  in_item,
  output logic           full,
  output logic           empty,
  input  logic           pop,
  output lpfd_pkg::out_t result,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data
);

  lpfd_pkg::cfg_wr_t    cfg;
  lpfd_pkg::job_t       f_job;
  lpfd_pkg::job_t       b_job;
  lpfd_pkg::mem_wr_t    mem_wr;
  lpfd_pkg::bank_free_t bank_free;
  logic                 f_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_not_empty;

  assign cfg_ready = 1'b1;
  assign cfg.en    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  lpfd_front #(
    .FRAME_MAX (FRAME_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .cfg       (cfg),
    .q_push    (f_push),
    .q_job     (f_job),
    .q_full    (q_full),
    .mem_wr    (mem_wr),
    .bank_free (bank_free)
  );

  lpfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .job_in    (f_job),
    .full      (q_full),
    .pop       (q_pop),
    .job_out   (b_job),
    .not_empty (q_not_empty)
  );

  lpfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .mem_wr      (mem_wr),
    .q_job       (b_job),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .bank_free   (bank_free),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

endmodule

FILE: design/lpfd_checker.sv
// Port-level checker for the deframer and its bind.
`timescale 1ns / 1ps
`include "length_prefixed_frame_deframer_assert.svh"
module lpfd_checker (
  input logic           clk,
  input logic           rst,
  input logic           empty,
  input logic           pop,
  input lpfd_pkg::out_t result
);

  `LPFD_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(result), "result changed while stalled")

  `LPFD_ASSERT_IMPLY(a_err_single, !empty && result.kind != lpfd_pkg::KIND_GOOD, result.last && result.payload_index == 5'd0 && result.payload_byte == 8'd0, "error result not a single word")

  `LPFD_ASSERT_NEXT(a_run_step, pop && !empty && !result.last, empty || (result.payload_index == $past(result.payload_index) + 5'd1 && result.frame_seq == $past(result.frame_seq)), "payload run broken")

  `LPFD_ASSERT_IMPLY(a_seq_nonzero, !empty && result.kind == lpfd_pkg::KIND_GOOD, result.frame_seq != 32'd0, "good frame with zero sequence")

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
